FILE: rtl/tcb_pkg.sv
// Shared types and constants of the text cell buffer.
package tcb_pkg;

  localparam int TCB_MAX_COLS  = 128;
  localparam int TCB_MAX_ROWS  = 64;
  localparam int TCB_CELL_BITS = 16;

  // signed width for coordinate plus scroll amount (covers 256 columns)
  localparam int TCB_SUM_W = 12;

  localparam int TCB_CFG_AW  = 2;
  localparam int TCB_CFG_DW  = 16;
  localparam int TCB_PORT_CW = 16;

  localparam logic [7:0]  TCB_COLS_RST  = 8'd80;
  localparam logic [6:0]  TCB_ROWS_RST  = 7'd25;
  localparam logic [15:0] TCB_CLEAR_RST = 16'd0;

  typedef enum logic [1:0] {
    FN_PUT    = 2'd0,
    FN_GET    = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_SCROLL = 2'd3
  } tcb_func_t;

  typedef enum logic [TCB_CFG_AW-1:0] {
    CFG_COLS  = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_CLEAR = 2'd2
  } tcb_cfg_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_GET  = 1'b1
  } tcb_state_t;

  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_en;
  } tcb_walk_ctl_t;

endpackage

FILE: rtl/tcb_cell_ram.sv
// Cell store: one write port, one read port with registered read data.
module tcb_cell_ram import tcb_pkg::*; #(
  parameter int DEPTH = TCB_MAX_COLS * TCB_MAX_ROWS,
  parameter int AW    = 13,
  parameter int DW    = TCB_CELL_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tcb_walker.sv
// Cell walker for clear, scroll and the post-reset clearing pass.
module tcb_walker import tcb_pkg::*; #(
  parameter int MAX_COLS  = TCB_MAX_COLS,
  parameter int MAX_ROWS  = TCB_MAX_ROWS,
  parameter int CELL_BITS = TCB_CELL_BITS,
  parameter int XW        = 8,
  parameter int YW        = 7,
  parameter int AW        = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [XW-1:0]        start_w,
  input  logic [YW-1:0]        start_h,
  input  logic signed [7:0]    start_dr,
  input  logic signed [8:0]    start_dc,
  input  logic [CELL_BITS-1:0] start_fill,
  input  logic                 start_force,
  input  logic [CELL_BITS-1:0] rdata,
  output tcb_walk_ctl_t        ctl,
  output logic [AW-1:0]        rd_addr,
  output logic [AW-1:0]        wr_addr,
  output logic [CELL_BITS-1:0] wr_data
);

  localparam int SW = TCB_SUM_W;
  localparam logic signed [SW-1:0] ColLim = SW'(MAX_COLS);
  localparam logic signed [SW-1:0] RowLim = SW'(MAX_ROWS);

  logic                 act_r, act_nxt;
  logic [XW-1:0]        x_r, x_nxt, w_r;
  logic [YW-1:0]        y_r, y_nxt, h_r;
  logic signed [SW-1:0] dr_r, dc_r;
  logic [CELL_BITS-1:0] fill_r;
  logic                 force_r, desc_r;
  logic                 p2_v_r;
  logic                 p2_ok_r;
  logic [AW-1:0]        p2_addr_r;

  logic signed [SW-1:0] dr_ext, dc_ext, dr_cl, dc_cl;
  logic signed [SW-1:0] sx, sy;
  logic                 src_ok, last;
  logic [AW-1:0]        dst_addr;

  // clamp scroll amounts
  always_comb begin
    dr_ext = SW'(start_dr);
    dc_ext = SW'(start_dc);
    dr_cl  = dr_ext;
    dc_cl  = dc_ext;
    if (dr_ext > RowLim) dr_cl = RowLim;
    else if (dr_ext < -RowLim) dr_cl = -RowLim;
    if (dc_ext > ColLim) dc_cl = ColLim;
    else if (dc_ext < -ColLim) dc_cl = -ColLim;
  end

  // source of the current destination cell
  always_comb begin
    sx = $signed({{(SW-XW){1'b0}}, x_r}) + dc_r;
    sy = $signed({{(SW-YW){1'b0}}, y_r}) + dr_r;
    src_ok = !force_r && (sx >= 0) && (sx < $signed({{(SW-XW){1'b0}}, w_r}))
             && (sy >= 0) && (sy < $signed({{(SW-YW){1'b0}}, h_r}));
    rd_addr  = AW'(int'(sy[YW-1:0]) * MAX_COLS + int'(sx[XW-1:0]));
    dst_addr = AW'(int'(y_r) * MAX_COLS + int'(x_r));
  end

  // walk order follows the scroll direction so no source is overwritten early
  always_comb begin
    act_nxt = act_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (desc_r) begin
      last = (x_r == '0) && (y_r == '0);
    end else begin
      last = (x_r == w_r - 1'b1) && (y_r == h_r - 1'b1);
    end
    if (act_r) begin
      if (last) begin
        act_nxt = 1'b0;
      end else if (desc_r) begin
        if (x_r == '0) begin
          x_nxt = w_r - 1'b1;
          y_nxt = y_r - 1'b1;
        end else begin
          x_nxt = x_r - 1'b1;
        end
      end else begin
        if (x_r == w_r - 1'b1) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b1;
      x_r     <= '0;
      y_r     <= '0;
      w_r     <= XW'(MAX_COLS);
      h_r     <= YW'(MAX_ROWS);
      dr_r    <= '0;
      dc_r    <= '0;
      fill_r  <= '0;
      force_r <= 1'b1;
      desc_r  <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      p2_v_r <= act_r;
      if (start) begin
        act_r   <= (start_w != '0) && (start_h != '0);
        w_r     <= start_w;
        h_r     <= start_h;
        dr_r    <= dr_cl;
        dc_r    <= dc_cl;
        fill_r  <= start_fill;
        force_r <= start_force;
        desc_r  <= (dr_cl < 0) || ((dr_cl == 0) && (dc_cl < 0));
        if ((dr_cl < 0) || ((dr_cl == 0) && (dc_cl < 0))) begin
          x_r <= start_w - 1'b1;
          y_r <= start_h - 1'b1;
        end else begin
          x_r <= '0;
          y_r <= '0;
        end
      end else begin
        act_r <= act_nxt;
        x_r   <= x_nxt;
        y_r   <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    p2_ok_r   <= src_ok;
    p2_addr_r <= dst_addr;
  end

  assign ctl.busy  = act_r | p2_v_r;
  assign ctl.rd_en = act_r & src_ok;
  assign ctl.wr_en = p2_v_r;
  assign wr_addr   = p2_addr_r;
  assign wr_data   = p2_ok_r ? rdata : fill_r;

endmodule

FILE: rtl/text_cell_buffer_with_scroll.sv
// Text cell buffer with scroll: top level.
//
// Input transactions arrive on in_* (tuser = operation, tdata = operands);
// each gives exactly one result transaction on out_* (tdata = cell read,
// tuser = in_range). Operations: put writes one cell, get reads one,
// clear fills the area in use with clear_cell, scroll moves the area in use
// and fills uncovered cells with clear_cell.
// Put: result in the cycle after acceptance. Get in the area: the cell
// passes the RAM read register, then the result register. Clear and
// scroll: result in the cycle after acceptance; the walker then visits
// each cell in use once per cycle through the single RAM read and write
// port pair, so no new item is taken until the walk is done. After reset
// the whole RAM is cleared while in_tready stays low; cfg writes are
// taken at any time. The result register holds while out_tready is low;
// a new item is only accepted once the register is empty or being drained
// in that cycle. Configuration is to be written by the user through
// cfg_we/cfg_addr/cfg_wdata while idle; the block does not enforce it.
module text_cell_buffer_with_scroll import tcb_pkg::*; #(
  parameter int MAX_COLS  = TCB_MAX_COLS,
  parameter int MAX_ROWS  = TCB_MAX_ROWS,
  parameter int CELL_BITS = TCB_CELL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // col[7:0], row[14:8], write_cell[30:15], scroll_rows[38:31], scroll_cols[47:39]
  input  logic [47:0]           in_tdata,
  // func[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_cell[15:0]
  output logic [TCB_PORT_CW-1:0] out_tdata,
  // in_range[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [TCB_CFG_AW-1:0] cfg_addr,
  input  logic [TCB_CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_COLS + 1);
  localparam int YW    = $clog2(MAX_ROWS + 1);

  logic [7:0]  cols_r;
  logic [6:0]  rows_r;
  logic [15:0] clear_r;

  tcb_state_t state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TCB_PORT_CW-1:0] out_data_r, out_data_nxt;
  logic                   out_range_r, out_range_nxt;

  tcb_func_t in_func;
  logic [7:0]  in_col;
  logic [6:0]  in_row;
  logic [15:0] in_wcell;
  logic signed [7:0] in_dr;
  logic signed [8:0] in_dc;

  logic [XW-1:0] eff_cols;
  logic [YW-1:0] eff_rows;
  logic          in_area, in_acc, walk_start, put_we, get_re;
  logic [AW-1:0] cell_addr;

  tcb_walk_ctl_t        walk;
  logic [AW-1:0]        walk_raddr, walk_waddr;
  logic [CELL_BITS-1:0] walk_wdata, rdata;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [CELL_BITS-1:0] mem_wdata;

  assign in_func  = tcb_func_t'(in_tuser);
  assign in_col   = in_tdata[7:0];
  assign in_row   = in_tdata[14:8];
  assign in_wcell = in_tdata[30:15];
  assign in_dr    = $signed(in_tdata[38:31]);
  assign in_dc    = $signed(in_tdata[47:39]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= TCB_COLS_RST;
      rows_r  <= TCB_ROWS_RST;
      clear_r <= TCB_CLEAR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COLS:  cols_r  <= cfg_wdata[7:0];
        CFG_ROWS:  rows_r  <= cfg_wdata[6:0];
        CFG_CLEAR: clear_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_cols  = (int'(cols_r) > MAX_COLS) ? XW'(MAX_COLS) : XW'(cols_r);
    eff_rows  = (int'(rows_r) > MAX_ROWS) ? YW'(MAX_ROWS) : YW'(rows_r);
    in_area   = (int'(in_col) < int'(eff_cols)) && (int'(in_row) < int'(eff_rows));
    cell_addr = AW'(int'(in_row) * MAX_COLS + int'(in_col));
  end

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    walk_start    = 1'b0;
    put_we        = 1'b0;
    get_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_range_nxt = out_range_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = !walk.busy && (!out_valid_r || out_tready);
        if (in_tvalid && in_tready) begin
          case (in_func)
            FN_PUT: begin
              put_we        = in_area;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_range_nxt = in_area;
            end
            FN_GET: begin
              if (in_area) begin
                get_re    = 1'b1;
                state_nxt = ST_GET;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_range_nxt = 1'b0;
              end
            end
            FN_CLEAR, FN_SCROLL: begin
              walk_start    = 1'b1;
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_range_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_GET: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = TCB_PORT_CW'(rdata);
        out_range_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_range_r <= out_range_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_range_r;

  tcb_walker #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .CELL_BITS (CELL_BITS),
    .XW        (XW),
    .YW        (YW),
    .AW        (AW)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (walk_start),
    .start_w     (eff_cols),
    .start_h     (eff_rows),
    .start_dr    (in_dr),
    .start_dc    (in_dc),
    .start_fill  (CELL_BITS'(clear_r)),
    .start_force (in_func == FN_CLEAR),
    .rdata       (rdata),
    .ctl         (walk),
    .rd_addr     (walk_raddr),
    .wr_addr     (walk_waddr),
    .wr_data     (walk_wdata)
  );

  assign mem_we    = walk.wr_en | put_we;
  assign mem_waddr = walk.wr_en ? walk_waddr : cell_addr;
  assign mem_wdata = walk.wr_en ? walk_wdata : CELL_BITS'(in_wcell);
  assign mem_re    = walk.rd_en | get_re;
  assign mem_raddr = walk.rd_en ? walk_raddr : cell_addr;

  tcb_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (CELL_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("RAM read and write hit the same cell");

  a_get_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GET |-> !walk.busy)
    else $error("get read overlaps a cell walk");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc) || $past(state_r == ST_GET))
    else $error("result without a transaction");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GET |=> out_valid_r && out_range_r)
    else $error("get result missing");
`endif

endmodule

FILE: test/tcb_cell_checker.sv
// Checker for the text cell buffer: shadow store, expected replies and comparison.
module tcb_cell_checker import tcb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [47:0]            in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [TCB_PORT_CW-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [TCB_CFG_AW-1:0]  cfg_addr,
  input  logic [TCB_CFG_DW-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [TCB_CELL_BITS-1:0] cell_val;
    logic                     in_range;
  } cell_reply_t;

  logic [TCB_CELL_BITS-1:0] screen [TCB_MAX_COLS*TCB_MAX_ROWS];
  logic [TCB_CELL_BITS-1:0] shadow [TCB_MAX_COLS*TCB_MAX_ROWS];
  logic [7:0]               cols_reg;
  logic [6:0]               rows_reg;
  logic [15:0]              blank_cell;
  cell_reply_t              replies_due [$];
  cell_reply_t              want;

  function automatic int span_cols();
    return (cols_reg > TCB_MAX_COLS) ? TCB_MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int span_rows();
    return (rows_reg > TCB_MAX_ROWS) ? TCB_MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic cell_reply_t predict_reply(input tcb_func_t op, input logic [47:0] d);
    cell_reply_t             r;
    int                      w, h, c, rw, dr, dc, sx, sy;
    logic signed [7:0]       sr;
    logic signed [8:0]       sc;
    w  = span_cols();
    h  = span_rows();
    c  = int'(d[7:0]);
    rw = int'(d[14:8]);
    sr = d[38:31];
    sc = d[47:39];
    r  = '0;
    case (op)
      FN_PUT: begin
        if (c < w && rw < h) begin
          screen[rw*TCB_MAX_COLS+c] = d[30:15];
          r.in_range = 1'b1;
        end
      end
      FN_GET: begin
        if (c < w && rw < h) begin
          r.cell_val = screen[rw*TCB_MAX_COLS+c];
          r.in_range = 1'b1;
        end
      end
      FN_CLEAR: begin
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            screen[y*TCB_MAX_COLS+x] = blank_cell;
      end
      default: begin
        dr = int'(sr);
        dc = int'(sc);
        if (dr > TCB_MAX_ROWS) dr = TCB_MAX_ROWS;
        else if (dr < -TCB_MAX_ROWS) dr = -TCB_MAX_ROWS;
        if (dc > TCB_MAX_COLS) dc = TCB_MAX_COLS;
        else if (dc < -TCB_MAX_COLS) dc = -TCB_MAX_COLS;
        shadow = screen;
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            sx = x + dc;
            sy = y + dr;
            if (sx >= 0 && sx < w && sy >= 0 && sy < h)
              screen[y*TCB_MAX_COLS+x] = shadow[sy*TCB_MAX_COLS+sx];
            else
              screen[y*TCB_MAX_COLS+x] = blank_cell;
          end
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = '0;
      cols_reg   = TCB_COLS_RST;
      rows_reg   = TCB_ROWS_RST;
      blank_cell = TCB_CLEAR_RST;
      replies_due.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready)
        replies_due.push_back(predict_reply(tcb_func_t'(in_tuser), in_tdata));
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result transaction, cell %h in_range %0b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_tdata !== want.cell_val) begin
            $display("%0t: read_cell expected %h, got %h", $time, want.cell_val, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.in_range) begin
            $display("%0t: in_range expected %0b, got %0b", $time, want.in_range, out_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COLS:  cols_reg   = cfg_wdata[7:0];
          CFG_ROWS:  rows_reg   = cfg_wdata[6:0];
          CFG_CLEAR: blank_cell = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    pending = replies_due.size();
  end

endmodule

FILE: test/text_cell_buffer_with_scroll_tb.sv
// Testbench top for the text cell buffer: stimulus, flow control and verdict.
module text_cell_buffer_with_scroll_tb;
  import tcb_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [47:0]            in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TCB_PORT_CW-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [TCB_CFG_AW-1:0]  cfg_addr;
  logic [TCB_CFG_DW-1:0]  cfg_wdata;

  int         chk_fails;
  int         chk_pending;
  int         burst_left = 0;
  int         rx_mode = 0;
  int         rx_left = 0;
  int         rx_tick = 0;
  logic [7:0] cur_cols = TCB_COLS_RST;
  logic [6:0] cur_rows = TCB_ROWS_RST;

  text_cell_buffer_with_scroll i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tcb_cell_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (chk_fails),
    .pending    (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stall pattern: free-running, random, mostly stalled, periodic
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= int'($urandom_range(0, 3));
      rx_left <= int'($urandom_range(50, 300));
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_tick % 7) < 3);
    endcase
  end

  function automatic int visible_area();
    int w, h;
    w = (cur_cols > TCB_MAX_COLS) ? TCB_MAX_COLS : int'(cur_cols);
    h = (cur_rows > TCB_MAX_ROWS) ? TCB_MAX_ROWS : int'(cur_rows);
    return w * h;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input tcb_func_t op, input logic [7:0] c, input logic [6:0] r,
                           input logic [15:0] v, input logic [7:0] sr, input logic [8:0] sc);
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 40));
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sc, sr, v, r, c};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // hold off until every reply is back and any walk has finished
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (chk_pending != 0) @(negedge clk);
    repeat (visible_area() + 4) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] c, input logic [6:0] r, input logic [15:0] k);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_COLS;
    cfg_wdata <= {8'd0, c};
    @(negedge clk);
    cfg_addr  <= CFG_ROWS;
    cfg_wdata <= {9'd0, r};
    @(negedge clk);
    cfg_addr  <= CFG_CLEAR;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_cols = c;
    cur_rows = r;
  endtask

  initial begin
    int         n_items, walks, pick, ec, er;
    bit         wide;
    logic [7:0] c, nc;
    logic [6:0] r, nr;
    logic [7:0] sr;
    logic [8:0] sc;
    logic [15:0] nk;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = FN_PUT;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_COLS;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    set_config(8'd80, 7'd25, 16'hA5A5);
    send_item(FN_GET,    8'd0,   7'd0,   16'h0000, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd0,   7'd0,   16'h0001, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd79,  7'd24,  16'hFFFF, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd80,  7'd24,  16'h1234, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd79,  7'd25,  16'h4321, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd255, 7'd127, 16'hFFFF, 8'hFF, 9'h1FF);
    send_item(FN_GET,    8'd79,  7'd24,  16'h0000, 8'h00, 9'h000);
    send_item(FN_GET,    8'd80,  7'd24,  16'h0000, 8'h00, 9'h000);
    send_item(FN_GET,    8'd255, 7'd127, 16'hFFFF, 8'hFF, 9'h1FF);
    send_item(FN_GET,    8'd0,   7'd0,   16'h0000, 8'h00, 9'h000);
    send_item(FN_SCROLL, 8'd0,   7'd0,   16'h0000, 8'h00, 9'h000);
    send_item(FN_SCROLL, 8'd0,   7'd0,   16'h0000, 8'h01, 9'h001);
    send_item(FN_GET,    8'd78,  7'd23,  16'h0000, 8'h00, 9'h000);
    send_item(FN_GET,    8'd79,  7'd24,  16'h0000, 8'h00, 9'h000);
    send_item(FN_SCROLL, 8'd0,   7'd0,   16'h0000, 8'hFF, 9'h1FF);
    send_item(FN_GET,    8'd79,  7'd24,  16'h0000, 8'h00, 9'h000);
    send_item(FN_SCROLL, 8'd0,   7'd0,   16'h0000, 8'h7F, 9'h100);
    send_item(FN_GET,    8'd79,  7'd24,  16'h0000, 8'h00, 9'h000);
    send_item(FN_PUT,    8'd5,   7'd5,   16'h5A5A, 8'h00, 9'h000);
    send_item(FN_CLEAR,  8'd5,   7'd5,   16'h0000, 8'h00, 9'h000);
    send_item(FN_GET,    8'd5,   7'd5,   16'h0000, 8'h00, 9'h000);
    send_item(FN_SCROLL, 8'd0,   7'd0,   16'h0000, 8'h80, 9'h0FF);
    send_item(FN_GET,    8'd0,   7'd0,   16'h0000, 8'h00, 9'h000);

    for (int p = 0; p < 15; p++) begin
      settle();
      nk = 16'($urandom);
      case (p)
        0: begin nc = 8'd255; nr = 7'd127; nk = 16'hFFFF; end
        1: begin nc = 8'd0;   nr = 7'd10; end
        2: begin nc = 8'd12;  nr = 7'd0; end
        3: begin nc = 8'd1;   nr = 7'd1; end
        4: begin nc = 8'd128; nr = 7'd64;  nk = 16'h0000; end
        5: begin nc = 8'd128; nr = 7'd1; end
        6: begin nc = 8'd1;   nr = 7'd64; end
        default: begin
          nc = 8'($urandom_range(1, 16));
          nr = 7'($urandom_range(1, 8));
        end
      endcase
      set_config(nc, nr, nk);
      n_items = (nc == 0 || nr == 0) ? 20 : 80;
      wide    = visible_area() > 256;
      walks   = 0;
      ec = (cur_cols > TCB_MAX_COLS) ? TCB_MAX_COLS : int'(cur_cols);
      er = (cur_rows > TCB_MAX_ROWS) ? TCB_MAX_ROWS : int'(cur_rows);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          c = 8'($urandom_range(0, ec));
          r = 7'($urandom_range(0, er));
        end else begin
          c = 8'($urandom);
          r = 7'($urandom);
        end
        if ($urandom_range(0, 9) < 7) begin
          sr = 8'(int'($urandom_range(0, 2*er + 2)) - (er + 1));
          sc = 9'(int'($urandom_range(0, 2*ec + 2)) - (ec + 1));
        end else begin
          sr = 8'($urandom);
          sc = 9'($urandom);
        end
        if (wide)
          pick = (walks < 3 && $urandom_range(0, 49) == 0) ? $urandom_range(80, 99)
                                                           : $urandom_range(0, 79);
        else
          pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_item(FN_PUT, c, r, 16'($urandom), sr, sc);
        end else if (pick < 80) begin
          send_item(FN_GET, c, r, 16'($urandom), sr, sc);
        end else begin
          walks++;
          send_item((pick < 88) ? FN_CLEAR : FN_SCROLL, c, r, 16'($urandom), sr, sc);
        end
      end
    end

    settle();
    if (chk_fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
